// ===== design/scfp_pkg.sv =====
`default_nettype none

package scfp_pkg;

  // One input transaction: a granule header or a single part 2 data bit.
  typedef struct packed {
    logic       func;
    logic       channel;
    logic       second_granule;
    logic       short_blocks;
    logic       mixed_blocks;
    logic [2:0] length_first;
    logic [1:0] length_second;
    logic [3:0] reuse_mask;
    logic       data_bit;
  } scfp_in_t;

  // One decoded scalefactor.
  typedef struct packed {
    logic       out_channel;
    logic       out_granule;
    logic [1:0] window;
    logic [4:0] band;
    logic [3:0] value;
    logic       last;
  } scfp_out_t;

  typedef enum logic [2:0] {
    S_IDLE,   // no granule open
    S_BITS,   // waiting for data bits of the current field
    S_SCAN,   // classify current entry: bits, copy or zero
    S_COPY,   // store read data arriving
    S_EMIT    // result ready for the output register
  } scfp_state_e;

  // Control from the sequencer to the field shifter.
  typedef struct packed {
    logic       clr;
    logic       shift;
    logic       bit_in;
    logic [2:0] len;
  } scfp_field_ctl_t;

  localparam int unsigned LONG_BANDS = 21;

  localparam logic [1:0] WIN_FIRST = 2'd0;
  localparam logic [1:0] WIN_LAST  = 2'd2;
  localparam logic [1:0] WIN_LONG  = 2'd3;

  localparam logic [4:0] LONG_LAST_BAND    = 5'd20;
  localparam logic [4:0] SHORT_LAST_BAND   = 5'd11;
  localparam logic [4:0] MIXED_LONG_LAST   = 5'd7;
  localparam logic [4:0] MIXED_SHORT_FIRST = 5'd3;
  localparam logic [4:0] RANGE2_LONG       = 5'd11;
  localparam logic [4:0] RANGE2_SHORT      = 5'd6;
  localparam logic [4:0] GROUP1_FIRST      = 5'd6;
  localparam logic [4:0] GROUP2_FIRST      = 5'd11;
  localparam logic [4:0] GROUP3_FIRST      = 5'd16;

endpackage

`default_nettype wire

// ===== design/scfp_field.sv =====
`default_nettype none

// Bit-serial field shifter: one data bit per shift, MSB first, keeps the
// low four bits and counts bits taken against the field length.
module scfp_field (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  scfp_pkg::scfp_field_ctl_t ctl_i,
  output logic [3:0]               value_o,
  output logic                     done_o
);
  import scfp_pkg::*;

  logic [3:0] acc_q, acc_d;
  logic [2:0] cnt_q, cnt_d;
  logic [3:0] acc_shift;
  logic [2:0] cnt_inc;

  assign acc_shift = {acc_q[2:0], ctl_i.bit_in};
  assign cnt_inc   = cnt_q + 3'd1;
  assign done_o    = ctl_i.shift && (cnt_inc >= ctl_i.len);
  assign value_o   = acc_shift;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (ctl_i.clr || done_o) begin
      acc_d = '0;
      cnt_d = '0;
    end else if (ctl_i.shift) begin
      acc_d = acc_shift;
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/scfp_store.sv =====
`default_nettype none

// Granule 0 long scalefactor store, one write and one registered read port.
module scfp_store #(
  parameter int unsigned DEPTH = 42,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [3:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [3:0]    rdata_o
);
  import scfp_pkg::*;

  logic [3:0] mem_q [DEPTH];
  logic [3:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/layer3_scalefactor_parser_core.sv =====
`default_nettype none

// MPEG-1 Layer III scalefactor parser.
// Input channel (in_valid_i / in_stall_o / in_data_i): a header transaction
// (func = 0) opens one granule of one channel; data transactions (func = 1)
// then deliver the part 2 bits one per transaction, MSB first. Data bits
// arriving with no granule open are dropped. A header always restarts.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transaction
// per scalefactor, in bitstream order, last = 1 on the final one.
// Flow: a field's final bit is accepted into the pending value register; in
// the emit state the result moves to the output register once that is free.
// Between fields the sequencer classifies the next entry in its scan state,
// so input is stalled in the scan and emit states; entries copied from
// granule 0 (scan, copy, emit; one store read) or of zero length (scan, emit)
// are produced without input and hold in_stall_o high meanwhile. Data bits
// themselves go in at one per cycle through the bit-serial field shifter while in_stall_o is low.
// A held output register lets the sequencer run on while a result waits;
// when the receiver stalls with the register full, the sequencer holds in
// its emit state and input stalls. Reset empties the output register and
// closes any open granule; the granule 0 store is not cleared.
module layer3_scalefactor_parser_core #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scfp_pkg::scfp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scfp_pkg::scfp_out_t out_data_o
);
  import scfp_pkg::*;

  localparam int unsigned DEPTH = CHANNELS * LONG_BANDS;
  localparam int unsigned AW    = $clog2(DEPTH);

  scfp_state_e state_q, state_d;

  // header fields of the open granule
  logic       hdr_ch_q, hdr_gr_q, hdr_short_q;
  logic [2:0] hdr_len1_q;
  logic [1:0] hdr_len2_q;
  logic [3:0] hdr_reuse_q;

  // sequence position as window/band
  logic [1:0] win_q, win_d;
  logic [4:0] band_q, band_d;

  logic [3:0] val_q;
  logic       out_valid_q;
  scfp_out_t  out_q;

  logic in_acc, hdr_acc, bit_acc, out_free;
  logic emit, rd_en, range2, copy_c, last_c;
  logic [2:0] len_c;
  logic [1:0] group_c;
  logic ch_in;

  scfp_field_ctl_t field_ctl;
  logic [3:0] field_val;
  logic       field_done;
  logic [3:0] store_rdata;
  logic [AW-1:0] store_addr;
  logic          store_we;

  // handshakes
  assign in_stall_o = !((state_q == S_IDLE) || (state_q == S_BITS));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign hdr_acc    = in_acc && !in_data_i.func;
  assign bit_acc    = in_acc && in_data_i.func && (state_q == S_BITS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ch_in      = (CHANNELS > 1) ? in_data_i.channel : 1'b0;

  // current entry classification
  assign range2 = (win_q == WIN_LONG) ? (band_q >= RANGE2_LONG) : (band_q >= RANGE2_SHORT);
  assign len_c  = range2 ? {1'b0, hdr_len2_q} : hdr_len1_q;

  always_comb begin
    if (band_q < GROUP1_FIRST)      group_c = 2'd0;
    else if (band_q < GROUP2_FIRST) group_c = 2'd1;
    else if (band_q < GROUP3_FIRST) group_c = 2'd2;
    else                            group_c = 2'd3;
  end

  // reuse only for pure long granules of granule 1
  assign copy_c = hdr_gr_q && !hdr_short_q && (win_q == WIN_LONG) && hdr_reuse_q[group_c];
  assign last_c = (win_q == WIN_LONG) ? (!hdr_short_q && (band_q == LONG_LAST_BAND))
                                      : ((win_q == WIN_LAST) && (band_q == SHORT_LAST_BAND));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (hdr_acc) state_d = S_SCAN;
      end
      S_BITS: begin
        if (hdr_acc)                    state_d = S_SCAN;
        else if (bit_acc && field_done) state_d = S_EMIT;
      end
      S_SCAN: begin
        if (copy_c)             state_d = S_COPY;
        else if (len_c == 3'd0) state_d = S_EMIT;
        else                    state_d = S_BITS;
      end
      S_COPY: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = last_c ? S_IDLE : S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    emit             = (state_q == S_EMIT) && out_free;
    rd_en            = (state_q == S_SCAN) && copy_c;
    field_ctl.clr    = hdr_acc;
    field_ctl.shift  = bit_acc;
    field_ctl.bit_in = in_data_i.data_bit;
    field_ctl.len    = len_c;
  end

  // window/band stepping
  always_comb begin
    win_d  = win_q;
    band_d = band_q;
    if (hdr_acc) begin
      band_d = '0;
      win_d  = (in_data_i.short_blocks && !in_data_i.mixed_blocks) ? WIN_FIRST : WIN_LONG;
    end else if (emit) begin
      if (win_q == WIN_LONG) begin
        if (hdr_short_q && (band_q == MIXED_LONG_LAST)) begin
          win_d  = WIN_FIRST;
          band_d = MIXED_SHORT_FIRST;
        end else begin
          band_d = band_q + 5'd1;
        end
      end else if (win_q == WIN_LAST) begin
        win_d  = WIN_FIRST;
        band_d = band_q + 5'd1;
      end else begin
        win_d = win_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= '0;
      band_q      <= '0;
      out_valid_q <= 1'b0;
      hdr_ch_q    <= 1'b0;
      hdr_gr_q    <= 1'b0;
      hdr_short_q <= 1'b0;
      hdr_len1_q  <= '0;
      hdr_len2_q  <= '0;
      hdr_reuse_q <= '0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      band_q  <= band_d;
      if (emit)          out_valid_q <= 1'b1;
      else if (out_free) out_valid_q <= 1'b0;
      if (hdr_acc) begin
        hdr_ch_q    <= ch_in;
        hdr_gr_q    <= in_data_i.second_granule;
        hdr_short_q <= in_data_i.short_blocks;
        hdr_len1_q  <= in_data_i.length_first;
        hdr_len2_q  <= in_data_i.length_second;
        hdr_reuse_q <= in_data_i.reuse_mask;
      end
    end
  end

  // pending value and output register
  always_ff @(posedge clk_i) begin
    if (bit_acc && field_done)                       val_q <= field_val;
    else if ((state_q == S_SCAN) && !copy_c)         val_q <= '0;
    else if (state_q == S_COPY)                      val_q <= store_rdata;
    if (emit) begin
      out_q.out_channel <= hdr_ch_q;
      out_q.out_granule <= hdr_gr_q;
      out_q.window      <= win_q;
      out_q.band        <= band_q;
      out_q.value       <= val_q;
      out_q.last        <= last_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // store: granule 0 long scalefactors, mixed long bands included
  assign store_addr = hdr_ch_q ? AW'(32'(LONG_BANDS) + 32'(band_q)) : AW'(band_q);
  assign store_we   = emit && !hdr_gr_q && (win_q == WIN_LONG);

  scfp_field u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (field_ctl),
    .value_o (field_val),
    .done_o  (field_done)
  );

  scfp_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_addr),
    .wdata_i (val_q),
    .re_i    (rd_en),
    .raddr_i (store_addr),
    .rdata_o (store_rdata)
  );

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result formed while output register blocked");

  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.band <= LONG_LAST_BAND))
    else $error("band out of range");

  a_last_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last) |->
      ((out_data_o.band == LONG_LAST_BAND && out_data_o.window == WIN_LONG) ||
       (out_data_o.band == SHORT_LAST_BAND && out_data_o.window == WIN_LAST)))
    else $error("last flag on wrong entry");

  a_close_granule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_c) |=> (state_q == S_IDLE))
    else $error("granule not closed after last scalefactor");
`endif

endmodule

`default_nettype wire
